// ----- hw/rtl/lock_graph_deadlock_detector_assert.svh -----
// Assertion macros used by the checker.
`ifndef LOCK_GRAPH_DEADLOCK_DETECTOR_ASSERT_SVH
`define LOCK_GRAPH_DEADLOCK_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LGDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LGDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lgdd_pkg.sv -----
`default_nettype none
package lgdd_pkg;
  localparam int NUM_LOCKS = 16;
  localparam int NUM_PROCS = 32;
  localparam int NODE_CNT  = NUM_LOCKS + NUM_PROCS;
  localparam int NODE_W    = $clog2(NODE_CNT + 1);
  localparam int LOCK_W    = 4;
  localparam int PROC_W    = 5;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_GRANT   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_DETECT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_NODE = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_STEP,
    S_POP,
    S_EMIT_TOP,
    S_RD,
    S_EMIT
  } state_t;

  // Index of the lowest set bit; zero for an empty vector.
  function automatic logic [NODE_W-1:0] lowest_bit(input logic [NODE_CNT-1:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = NODE_CNT - 1; i >= 0; i--) begin
      if (v[i]) r = NODE_W'(i);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/lgdd_stack.sv -----
`default_nettype none
module lgdd_stack (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [lgdd_pkg::NODE_W-1:0] wr_addr,
  input  wire logic [lgdd_pkg::NODE_W-1:0] wr_data,
  input  wire logic [lgdd_pkg::NODE_W-1:0] rd_addr,
  output logic      [lgdd_pkg::NODE_W-1:0] rd_data
);
  import lgdd_pkg::*;

  logic [NODE_W-1:0] mem [NODE_CNT];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lock_graph_deadlock_detector.sv -----
`default_nettype none
// Edge commands (request, grant, release): result strobes the cycle after start.
// Busy stays low for edge commands, so one can be taken every cycle.
// Detect: each DFS step runs in the shared neighbour/priority-encoder unit; a pop passes S_POP
// (path stack read) and each stacked path node S_RD then S_EMIT; busy holds for the whole walk.
// Sync active-high reset clears both edge matrices and the sequencer; results cannot stall.
module lock_graph_deadlock_detector (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] command,
  input  wire logic [4:0] process_id,
  input  wire logic [3:0] lock_id,
  output logic            valid,
  output logic [1:0]      kind,
  output logic            edge_found,
  output logic            node_is_lock,
  output logic [4:0]      node_number,
  output logic            last
);
  import lgdd_pkg::*;

  state_t state, state_next;

  logic [NUM_LOCKS-1:0] request_rows [NUM_PROCS];
  logic [NUM_PROCS-1:0] grant_rows [NUM_LOCKS];

  logic [LOCK_W-1:0]   start_lock;
  logic [NODE_W-1:0]   top, depth, idx;
  logic [NODE_CNT-1:0] on_path, fin;

  logic [NODE_CNT-1:0] nb_all, nb;
  logic [NODE_W-1:0]   c;
  logic [NODE_W-1:0]   proc_off;
  logic                hit, last_lock, acc, is_edge, in_range, had_req, had_grant;

  logic              wr_en;
  logic [NODE_W-1:0] rd_addr, rd_data;

  logic              emit, e_found, e_last;
  logic [1:0]        e_kind;
  logic [NODE_W-1:0] e_node;
  logic [NODE_W-1:0] node_off;

  lgdd_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (depth - NODE_W'(1)),
    .wr_data (top),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != S_IDLE);
  assign acc       = start && !busy;
  assign is_edge   = (command != CMD_DETECT);
  assign in_range  = ({1'b0, process_id} < (PROC_W + 1)'(NUM_PROCS)) &&
                     ({1'b0, lock_id} < (LOCK_W + 1)'(NUM_LOCKS));
  assign had_req   = request_rows[process_id][lock_id];
  assign had_grant = grant_rows[lock_id][process_id];
  assign last_lock = (start_lock == LOCK_W'(NUM_LOCKS - 1));

  // Neighbour set of the node on top of the search path.
  assign proc_off = top - NODE_W'(NUM_LOCKS);
  always_comb begin
    if (top < NODE_W'(NUM_LOCKS))
      nb_all = NODE_CNT'(grant_rows[top[LOCK_W-1:0]]) << NUM_LOCKS;
    else
      nb_all = NODE_CNT'(request_rows[proc_off[PROC_W-1:0]]);
  end
  assign nb  = nb_all & ~fin;
  assign c   = lowest_bit(nb);
  assign hit = on_path[c];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (acc && !is_edge) state_next = S_START;
      S_START:    state_next = S_STEP;
      S_STEP: begin
        if (nb == '0) begin
          if (depth == NODE_W'(1)) state_next = last_lock ? S_IDLE : S_START;
          else state_next = S_POP;
        end else if (hit) begin
          state_next = (depth == NODE_W'(1)) ? S_IDLE : S_EMIT_TOP;
        end
      end
      S_POP:      state_next = S_STEP;
      S_EMIT_TOP: state_next = (depth == NODE_W'(2)) ? S_IDLE : S_RD;
      S_RD:       state_next = S_EMIT;
      S_EMIT:     state_next = (idx == NODE_W'(1)) ? S_IDLE : S_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    e_kind  = KIND_ACK;
    e_found = 1'b0;
    e_node  = '0;
    e_last  = 1'b0;
    wr_en   = 1'b0;
    rd_addr = idx;
    unique case (state)
      S_IDLE: begin
        if (acc && is_edge) begin
          emit   = 1'b1;
          e_last = 1'b1;
          if (in_range) begin
            if (command == CMD_GRANT) e_found = had_req;
            else if (command == CMD_RELEASE) e_found = had_req || had_grant;
          end
        end
      end
      S_STEP: begin
        if (nb == '0) begin
          rd_addr = depth - NODE_W'(2);
          if (depth == NODE_W'(1) && last_lock) begin
            emit   = 1'b1;
            e_kind = KIND_NONE;
            e_last = 1'b1;
          end
        end else if (hit) begin
          emit   = 1'b1;
          e_kind = KIND_NODE;
          e_node = c;
          e_last = (depth == NODE_W'(1));
        end else begin
          wr_en = 1'b1;
        end
      end
      S_EMIT_TOP: begin
        emit   = 1'b1;
        e_kind = KIND_NODE;
        e_node = top;
        e_last = (depth == NODE_W'(2));
      end
      S_EMIT: begin
        emit   = 1'b1;
        e_kind = KIND_NODE;
        e_node = rd_data;
        e_last = (idx == NODE_W'(1));
      end
      default: ;
    endcase
  end

  assign node_off = e_node - NODE_W'(NUM_LOCKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) request_rows[i] <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) grant_rows[i] <= '0;
    end else begin
      state <= state_next;
      valid <= emit;
      if (state == S_IDLE && acc && is_edge && in_range) begin
        unique case (command)
          CMD_REQUEST: request_rows[process_id][lock_id] <= 1'b1;
          CMD_GRANT: begin
            grant_rows[lock_id][process_id]   <= 1'b1;
            request_rows[process_id][lock_id] <= 1'b0;
          end
          CMD_RELEASE: begin
            if (had_req) request_rows[process_id][lock_id] <= 1'b0;
            else if (had_grant) grant_rows[lock_id][process_id] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (acc && !is_edge) start_lock <= '0;
      S_START: begin
        top     <= NODE_W'(start_lock);
        depth   <= NODE_W'(1);
        on_path <= NODE_CNT'(1) << start_lock;
        fin     <= '0;
      end
      S_STEP: begin
        if (nb == '0) begin
          fin[top]     <= 1'b1;
          on_path[top] <= 1'b0;
          depth        <= depth - NODE_W'(1);
          if (depth == NODE_W'(1) && !last_lock) start_lock <= start_lock + LOCK_W'(1);
        end else if (!hit) begin
          top        <= c;
          depth      <= depth + NODE_W'(1);
          on_path[c] <= 1'b1;
        end
      end
      S_POP:      top <= rd_data;
      S_EMIT_TOP: idx <= depth - NODE_W'(2);
      S_EMIT:     idx <= idx - NODE_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind       <= e_kind;
      edge_found <= e_found;
      last       <= e_last;
      if (e_kind == KIND_NODE && e_node < NODE_W'(NUM_LOCKS)) begin
        node_is_lock <= 1'b1;
        node_number  <= 5'(e_node);
      end else if (e_kind == KIND_NODE) begin
        node_is_lock <= 1'b0;
        node_number  <= 5'(node_off);
      end else begin
        node_is_lock <= 1'b0;
        node_number  <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lgdd_checker.sv -----
`default_nettype none
`include "lock_graph_deadlock_detector_assert.svh"
module lgdd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] command,
  input wire logic       valid,
  input wire logic [1:0] kind,
  input wire logic       edge_found,
  input wire logic       node_is_lock,
  input wire logic [4:0] node_number,
  input wire logic       last
);
  import lgdd_pkg::*;

  `LGDD_ASSERT_NEXT(a_edge_ack, start && !busy && command != CMD_DETECT, valid && kind == KIND_ACK && last, "edge command not acknowledged next cycle")
  `LGDD_ASSERT_NOW(a_ack_last, valid && kind == KIND_ACK, last && !node_is_lock && node_number == 5'd0, "bad acknowledge")
  `LGDD_ASSERT_NOW(a_none_clean, valid && kind == KIND_NONE, last && !edge_found && !node_is_lock && node_number == 5'd0, "bad no-deadlock result")
  // the final cycle node is the start lock's child, always a process
  `LGDD_ASSERT_NOW(a_node_found, valid && kind == KIND_NODE, !edge_found && !(last && node_is_lock), "bad cycle node report")
  `LGDD_ASSERT_NOW(a_idle_after_last, valid && last && kind != KIND_ACK, !busy, "busy after final result")
endmodule

bind lock_graph_deadlock_detector lgdd_checker u_lgdd_checker (.*);
`default_nettype wire
